FILE: rtl/freq_to_midi_key_and_bend_top_assert.svh
// Assertion macros for the frequency-to-key block.
`ifndef FREQ_TO_MIDI_KEY_AND_BEND_TOP_ASSERT_SVH
`define FREQ_TO_MIDI_KEY_AND_BEND_TOP_ASSERT_SVH

// A condition that must imply a consequence on the next clock edge.
`define F2M_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// A condition that must hold at every clock edge.
`define F2M_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

`endif

FILE: rtl/f2m_pkg.sv
package f2m_pkg;
  localparam int unsigned KeyW    = 7;
  localparam int unsigned BendW   = 14;
  localparam int unsigned StatW   = 2;
  localparam int unsigned RangeW  = 15;
  localparam logic [RangeW-1:0] RangeReset = 15'd512;
  localparam logic [BendW-1:0]  BendCentre = 14'd8192;
  localparam logic [BendW-1:0]  BendMax    = 14'd16383;
  localparam logic [63:0]       Log2440Q32 = 64'd37715652784;

  typedef enum logic [StatW-1:0] {
    STAT_OK   = 2'd0,
    STAT_SAT  = 2'd1,
    STAT_ZERO = 2'd2
  } status_e;
endpackage

FILE: rtl/f2m_log2.sv
// Pipelined log2 mantissa: one squaring step per stage, NBits stages.
// Each stage registers the square of a Q1.30 mantissa, so one 31x31
// multiplier stands between registers.
module f2m_log2 import f2m_pkg::*; #(
  parameter int unsigned NBits = 16,
  parameter int unsigned TagW  = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [30:0]     mant_i,
  input  logic [TagW-1:0] tag_i,
  output logic            vld_o,
  output logic [NBits-1:0] frac_o,
  output logic [TagW-1:0] tag_o
);
  logic [NBits:0]      vld_q;
  logic [30:0]         m_q   [NBits+1];
  logic [NBits-1:0]    fr_q  [NBits+1];
  logic [TagW-1:0]     tag_q [NBits+1];

  assign vld_q[0]  = vld_i;
  assign m_q[0]    = mant_i;
  assign fr_q[0]   = '0;
  assign tag_q[0]  = tag_i;

  for (genvar g = 0; g < NBits; g++) begin : g_step
    logic [61:0] sq;
    logic [31:0] m2;
    assign sq = 62'(m_q[g]) * 62'(m_q[g]);
    assign m2 = sq[61:30];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[g+1]   <= m2[31] ? m2[31:1] : m2[30:0];
        fr_q[g+1]  <= {fr_q[g][NBits-2:0], m2[31]};
        tag_q[g+1] <= tag_q[g];
      end
    end
  end

  assign vld_o  = vld_q[NBits];
  assign frac_o = fr_q[NBits];
  assign tag_o  = tag_q[NBits];
endmodule

FILE: rtl/freq_to_midi_key_and_bend_top.sv
// Channel | Dir | Fields (low bit up)
// s_axis  | in  | tdata[29:0] frequency
// m_axis  | out | tdata[6:0] note_key, [20:7] bend_value, [22:21] status
// cfg     | in  | cfg_wdata_i[14:0] bend_range_semitones
// One item is accepted every cycle while the output is not stalled.
// The log2 pipeline (one squaring multiplier per fraction bit) and the
// 14-step restoring divider for the bend set the depth.
// Reset clears all valid bits and loads a range of 2.0 semitones.
// A stall on the output freezes the whole pipeline; nothing is lost.
`include "freq_to_midi_key_and_bend_top_assert.svh"
module freq_to_midi_key_and_bend_top import f2m_pkg::*; #(
  parameter int unsigned FREQ_FRAC_BITS = 16,
  parameter int unsigned LOG_FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [29:0] frequency
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [6:0] key, [20:7] bend, [22:21] status
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i
);
  localparam int unsigned LF   = LOG_FRAC_BITS;
  localparam int unsigned SW   = LF + 12;    // signed semitone width
  localparam logic [63:0] Ref440Full =
    (Log2440Q32 + (64'd1 << (31 - LF))) >> (32 - LF);
  localparam logic signed [SW-1:0] Ref440 = SW'(Ref440Full);
  localparam logic signed [SW-1:0] One    = SW'(64'd1 << LF);
  localparam int unsigned QW   = LF + 24;    // quotient search width
  localparam int unsigned NW   = QW + 9;     // numerator width
  localparam int unsigned DW   = NW + BendW; // divider compare width

  logic [RangeW-1:0] range_q;
  logic              en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RangeReset;
    end else if (cfg_we_i) begin
      range_q <= cfg_wdata_i;
    end
  end

  // Stage A: leading-one search and normalization.
  logic [29:0] f;
  logic [4:0]  msb;
  logic        vld_a_q, zero_a_q;
  logic [30:0] mant_a_q;
  logic [4:0]  msb_a_q;
  logic [30:0] mant_d;

  assign f = s_axis_tdata[29:0];
  always_comb begin
    msb = '0;
    for (int i = 0; i < 30; i++) begin
      if (f[i]) msb = 5'(i);
    end
    mant_d = 31'({1'b0, f} << (5'd30 - msb));
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en) begin
      vld_a_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mant_a_q <= mant_d;
      msb_a_q  <= msb;
      zero_a_q <= (f == '0);
    end
  end

  logic          vld_l;
  logic [LF-1:0] frac_l;
  logic [5:0]    tag_l;

  f2m_log2 #(.NBits(LF), .TagW(6)) u_log2 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld_a_q), .mant_i(mant_a_q),
    .tag_i({zero_a_q, msb_a_q}), .vld_o(vld_l), .frac_o(frac_l), .tag_o(tag_l)
  );

  // Stage B: semitone number and key.
  logic signed [SW-1:0] lg, s_d, s_b_q, r_d;
  logic [KeyW-1:0] key_d, key_b_q;
  logic signed [SW-1:0] kr;
  logic            vld_b_q, zero_b_q;

  always_comb begin
    lg = (SW'($signed({1'b0, tag_l[4:0]})) - SW'(FREQ_FRAC_BITS)) * One
         + SW'({1'b0, frac_l});
    s_d = SW'(12) * (lg - Ref440) + SW'(69) * One;
    kr  = (s_d + (One >>> 1)) >>> LF;
    if (s_d < 0) key_d = '0;
    else if (kr > SW'(127)) key_d = 7'd127;
    else key_d = kr[KeyW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_b_q <= 1'b0;
    else if (en) vld_b_q <= vld_l;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s_b_q <= s_d; key_b_q <= key_d; zero_b_q <= tag_l[5];
    end
  end

  // Stage C: remainder magnitude and scaled numerator.
  logic [SW-1:0]    mag_d;
  logic [QW+8:0]    num_c_q;
  logic [QW+8:0]    den_c_q;
  logic             vld_c_q, zero_c_q, neg_c_q, rz_c_q, r0_c_q;
  logic [KeyW-1:0]  key_c_q;

  always_comb begin
    r_d   = s_b_q - SW'($signed({1'b0, key_b_q})) * One;
    mag_d = r_d < 0 ? SW'(-r_d) : SW'(r_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_c_q <= 1'b0;
    else if (en) vld_c_q <= vld_b_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      // q = (mag*2^22 + den) / (2*den), den = range << LF
      num_c_q  <= (QW+9)'({mag_d, 22'd0}) + ((QW+9)'(range_q) << LF);
      den_c_q  <= (QW+9)'(range_q) << (LF + 1);
      neg_c_q  <= r_d < 0;
      r0_c_q   <= r_d == 0;
      rz_c_q   <= range_q == '0;
      zero_c_q <= zero_b_q;
      key_c_q  <= key_b_q;
    end
  end

  // Stage D: saturation by compare against den*limit.
  // Quotient only matters up to 8192, so compare num with den*(lim+1).
  typedef struct packed {
    logic             use_q;
    logic             neg;
    status_e          st;
    logic [BendW-1:0] bend;
    logic [KeyW-1:0]  key;
  } side_t;

  logic [QW+24:0]   lim_hi, lim_lo;
  side_t            side_d;

  always_comb begin
    lim_hi = (QW+25)'(den_c_q) << 13;     // q > 8191
    lim_lo = lim_hi + (QW+25)'(den_c_q);  // q > 8192
    side_d.use_q = 1'b0;
    side_d.neg   = neg_c_q;
    side_d.st    = STAT_OK;
    side_d.bend  = BendCentre;
    side_d.key   = zero_c_q ? '0 : key_c_q;
    if (zero_c_q) begin
      side_d.st = STAT_ZERO;
    end else if (r0_c_q) begin
      side_d.bend = BendCentre;
    end else if (rz_c_q) begin
      side_d.bend = neg_c_q ? '0 : BendMax;
      side_d.st = STAT_SAT;
    end else if (!neg_c_q && (QW+25)'(num_c_q) >= lim_hi) begin
      side_d.bend = BendMax; side_d.st = STAT_SAT;
    end else if (neg_c_q && (QW+25)'(num_c_q) >= lim_lo) begin
      side_d.bend = '0; side_d.st = STAT_SAT;
    end else begin
      side_d.use_q = 1'b1;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  // The saturation checks keep the quotient below 2^14.
  logic              dv_vld_q [BendW+1];
  logic [NW-1:0]     rem_q    [BendW];
  logic [NW-1:0]     dvs_q    [BendW];
  logic [BendW-1:0]  quo_q    [BendW+1];
  side_t             side_q   [BendW+1];
  logic [DW-1:0]     dv_sh    [BendW];
  logic              dv_take  [BendW];
  logic              vld_e_q;

  always_comb begin
    for (int g = 0; g < BendW; g++) begin
      dv_sh[g]   = DW'(dvs_q[g]) << (BendW - 1 - g);
      dv_take[g] = DW'(rem_q[g]) >= dv_sh[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g <= BendW; g++) dv_vld_q[g] <= 1'b0;
      vld_e_q <= 1'b0;
    end else if (en) begin
      dv_vld_q[0] <= vld_c_q;
      for (int g = 0; g < BendW; g++) dv_vld_q[g+1] <= dv_vld_q[g];
      vld_e_q <= dv_vld_q[BendW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]  <= num_c_q;
      dvs_q[0]  <= den_c_q;
      quo_q[0]  <= '0;
      side_q[0] <= side_d;
      for (int g = 0; g < BendW; g++) begin
        if (g < BendW - 1) begin
          rem_q[g+1] <= dv_take[g] ? NW'(DW'(rem_q[g]) - dv_sh[g]) : rem_q[g];
          dvs_q[g+1] <= dvs_q[g];
        end
        quo_q[g+1]  <= {quo_q[g][BendW-2:0], dv_take[g]};
        side_q[g+1] <= side_q[g];
      end
    end
  end

  // Output stage: apply the quotient around the center.
  logic [BendW-1:0] bend_e;
  side_t            side_e;
  logic [23:0]      out_q;

  always_comb begin
    side_e = side_q[BendW];
    if (!side_e.use_q) bend_e = side_e.bend;
    else if (side_e.neg) bend_e = BendCentre - quo_q[BendW];
    else bend_e = BendCentre + quo_q[BendW];
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= {1'b0, side_e.st, bend_e, side_e.key};
  end

  assign m_axis_tvalid = vld_e_q;
  assign m_axis_tdata  = out_q;

  `F2M_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `F2M_ASSERT_ALWAYS(a_stat, !m_axis_tvalid || m_axis_tdata[22:21] != 2'd3)
  `F2M_ASSERT_ALWAYS(a_rdy, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
endmodule
